FILE: src/s1asc_pkg.sv
// Shared types, scan codes and character tables for the scan-code set 1 decoder.
package s1asc_pkg;

   localparam int ByteWidth = 8;
   localparam int CharWidth = 7;
   localparam int KeyWidth  = 6;

   // Scan codes with a special role
   localparam logic [ByteWidth-1:0] CodePrefix = 8'hE0;
   localparam logic [ByteWidth-1:0] CodeCtrl   = 8'h1D;
   localparam logic [ByteWidth-1:0] CodeAlt    = 8'h38;
   localparam logic [ByteWidth-1:0] CodeLShift = 8'h2A;
   localparam logic [ByteWidth-1:0] CodeRShift = 8'h36;
   localparam logic [ByteWidth-1:0] CodeCaps   = 8'h3A;
   localparam logic [ByteWidth-1:0] KeyCount   = 8'h3B;

   // Characters touched by the ctrl shortcut
   localparam logic [CharWidth-1:0] CharLowL = 7'h6C;
   localparam logic [CharWidth-1:0] CharLowU = 7'h75;
   localparam logic [CharWidth-1:0] CharLowA = 7'h61;
   localparam logic [CharWidth-1:0] CharLowZ = 7'h7A;
   localparam logic [CharWidth-1:0] CaseGap  = 7'h20;

   // Decoder output toward the result register
   typedef struct packed {
      logic                 emit;
      logic [CharWidth-1:0] ch;
   } dec_result_type;

   // Unshifted column
   function automatic logic [CharWidth-1:0] rom_plain(input logic [KeyWidth-1:0] key);
      logic [CharWidth-1:0] c;
      c = '0;
      case (key)
         6'h01: c = 7'h1B;  6'h02: c = 7'h31;  6'h03: c = 7'h32;  6'h04: c = 7'h33;
         6'h05: c = 7'h34;  6'h06: c = 7'h35;  6'h07: c = 7'h36;  6'h08: c = 7'h37;
         6'h09: c = 7'h38;  6'h0A: c = 7'h39;  6'h0B: c = 7'h30;  6'h0C: c = 7'h2D;
         6'h0D: c = 7'h3D;  6'h0E: c = 7'h08;  6'h0F: c = 7'h09;  6'h10: c = 7'h71;
         6'h11: c = 7'h77;  6'h12: c = 7'h65;  6'h13: c = 7'h72;  6'h14: c = 7'h74;
         6'h15: c = 7'h79;  6'h16: c = 7'h75;  6'h17: c = 7'h69;  6'h18: c = 7'h6F;
         6'h19: c = 7'h70;  6'h1A: c = 7'h5B;  6'h1B: c = 7'h5D;  6'h1C: c = 7'h0D;
         6'h1E: c = 7'h61;  6'h1F: c = 7'h73;  6'h20: c = 7'h64;  6'h21: c = 7'h66;
         6'h22: c = 7'h67;  6'h23: c = 7'h68;  6'h24: c = 7'h6A;  6'h25: c = 7'h6B;
         6'h26: c = 7'h6C;  6'h27: c = 7'h3B;  6'h28: c = 7'h27;  6'h29: c = 7'h60;
         6'h2B: c = 7'h5C;  6'h2C: c = 7'h7A;  6'h2D: c = 7'h78;  6'h2E: c = 7'h63;
         6'h2F: c = 7'h76;  6'h30: c = 7'h62;  6'h31: c = 7'h6E;  6'h32: c = 7'h6D;
         6'h33: c = 7'h2C;  6'h34: c = 7'h2E;  6'h35: c = 7'h2F;  6'h37: c = 7'h2A;
         6'h39: c = 7'h20;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Shifted column: letters go upper case, symbol keys have their own glyphs
   function automatic logic [CharWidth-1:0] rom_shift(input logic [KeyWidth-1:0] key);
      logic [CharWidth-1:0] p;
      logic [CharWidth-1:0] c;
      p = rom_plain(key);
      c = p;
      case (key)
         6'h02: c = 7'h21;  6'h03: c = 7'h40;  6'h04: c = 7'h23;  6'h05: c = 7'h24;
         6'h06: c = 7'h25;  6'h07: c = 7'h5E;  6'h08: c = 7'h26;  6'h09: c = 7'h2A;
         6'h0A: c = 7'h28;  6'h0B: c = 7'h29;  6'h0C: c = 7'h5F;  6'h0D: c = 7'h2B;
         6'h1A: c = 7'h7B;  6'h1B: c = 7'h7D;  6'h27: c = 7'h3A;  6'h28: c = 7'h22;
         6'h29: c = 7'h7E;  6'h2B: c = 7'h7C;  6'h33: c = 7'h3C;  6'h34: c = 7'h3E;
         6'h35: c = 7'h3F;
         default: begin
            if (p >= CharLowA && p <= CharLowZ) begin
               c = p - CaseGap;
            end
         end
      endcase
      return c;
   endfunction

   // Keys whose column follows shift alone (caps lock does not apply)
   function automatic logic is_symbol_key(input logic [KeyWidth-1:0] key);
      logic s;
      s = 1'b0;
      case (key)
         6'h1A, 6'h1B, 6'h27, 6'h28, 6'h29, 6'h2B, 6'h33, 6'h34, 6'h35: s = 1'b1;
         default: s = (key < 6'h0E);
      endcase
      return s;
   endfunction

endpackage

FILE: src/s1asc_decode.sv
// Decoder stage: prefix and modifier state, table lookup and ctrl shortcut.
module s1asc_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic [s1asc_pkg::ByteWidth-1:0]   scan_byte,
   output s1asc_pkg::dec_result_type         result
);

   logic prefix_ff, prefix_in;
   logic ctrl_ff, ctrl_in;
   logic shift_ff, shift_in;
   logic alt_ff, alt_in;
   logic caps_ff, caps_in;

   logic [s1asc_pkg::ByteWidth-1:0] made;
   logic [s1asc_pkg::KeyWidth-1:0]  key;
   logic                            known;
   logic                            upper;
   logic [s1asc_pkg::CharWidth-1:0] ch;

   assign made = {1'b0, scan_byte[s1asc_pkg::ByteWidth-2:0]};
   assign key  = scan_byte[s1asc_pkg::KeyWidth-1:0];

   // Valid make code: plain 0x01..0x3A, or prefixed ctrl / alt
   always_comb begin
      if (prefix_ff) begin
         known = (scan_byte == s1asc_pkg::CodeCtrl) || (scan_byte == s1asc_pkg::CodeAlt);
      end else begin
         known = (scan_byte != '0) && (scan_byte < s1asc_pkg::KeyCount);
      end
   end

   // Column pick and lookup
   always_comb begin
      upper = s1asc_pkg::is_symbol_key(key) ? shift_ff : (shift_ff ^ caps_ff);
      ch    = upper ? s1asc_pkg::rom_shift(key) : s1asc_pkg::rom_plain(key);
      if (ctrl_ff && (ch == s1asc_pkg::CharLowL || ch == s1asc_pkg::CharLowU)) begin
         ch = ch - s1asc_pkg::CharLowA;
      end
   end

   // Next state and result
   always_comb begin
      prefix_in   = prefix_ff;
      ctrl_in     = ctrl_ff;
      shift_in    = shift_ff;
      alt_in      = alt_ff;
      caps_in     = caps_ff;
      result.emit = 1'b0;
      result.ch   = ch;
      if (scan_byte == s1asc_pkg::CodePrefix) begin
         prefix_in = 1'b1;
      end else begin
         prefix_in = 1'b0;
         if (scan_byte[s1asc_pkg::ByteWidth-1]) begin
            // break code
            if (made == s1asc_pkg::CodeCtrl) begin
               ctrl_in = 1'b0;
            end else if (made == s1asc_pkg::CodeAlt) begin
               alt_in = 1'b0;
            end else if (!prefix_ff && (made == s1asc_pkg::CodeLShift ||
                                        made == s1asc_pkg::CodeRShift)) begin
               shift_in = 1'b0;
            end
         end else if (known) begin
            if (ch != '0) begin
               result.emit = 1'b1;
            end else if (scan_byte == s1asc_pkg::CodeCtrl) begin
               ctrl_in = 1'b1;
            end else if (scan_byte == s1asc_pkg::CodeAlt) begin
               alt_in = 1'b1;
            end else if (scan_byte == s1asc_pkg::CodeLShift ||
                         scan_byte == s1asc_pkg::CodeRShift) begin
               shift_in = 1'b1;
            end else if (scan_byte == s1asc_pkg::CodeCaps) begin
               caps_in = ~caps_ff;
            end
         end
      end
   end

   // State registers, updated once per decoded byte
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
         ctrl_ff   <= 1'b0;
         shift_ff  <= 1'b0;
         alt_ff    <= 1'b0;
         caps_ff   <= 1'b0;
      end else if (enable) begin
         prefix_ff <= prefix_in;
         ctrl_ff   <= ctrl_in;
         shift_ff  <= shift_in;
         alt_ff    <= alt_in;
         caps_ff   <= caps_in;
      end
   end

endmodule

FILE: src/scancode_set1_to_ascii.sv
// Top level: input register, decoder and result register of the scan-code decoder.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  req     | req_valid req_ready req_scan_byte | one raw set 1 byte
//  rsp     | rsp_valid rsp_ready rsp_ascii_char | one decoded character
//
// One byte per cycle sustained while results are not stalled; a taken byte passes
// the input register, then is decoded into the result register.
// Prefix, modifier and caps state update as each byte passes the decoder.
// Synchronous reset clears the decoder state and both stage valids.
// A stalled result holds the decoder; the input register takes a byte only while
// it is empty or advancing, so one byte at most waits behind a stalled character.
module scancode_set1_to_ascii (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [s1asc_pkg::ByteWidth-1:0]   req_scan_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [s1asc_pkg::CharWidth-1:0]   rsp_ascii_char
);

   logic                              in_valid_ff, in_valid_in;
   logic [s1asc_pkg::ByteWidth-1:0]   in_byte_ff;
   logic                              out_valid_ff, out_valid_in;
   logic [s1asc_pkg::CharWidth-1:0]   out_char_ff;
   logic                              advance;
   logic                              take;
   s1asc_pkg::dec_result_type         dec;

   // Stage handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance ? dec.emit : (out_valid_ff && !rsp_ready);

   s1asc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .scan_byte (in_byte_ff),
      .result    (dec)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_scan_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && dec.emit) begin
         out_char_ff <= dec.ch;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_ascii_char = out_char_ff;

   // A delivered character is never zero
   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char != '0))
      else $error("result character is zero");

   // An empty input register always takes a transaction
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input register empty but not ready");

   // A held byte stays put until the decoder consumes it
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held input byte lost or changed");

   // The decoder only runs when the result register can take its output
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_char_ff)))
      else $error("pending result overwritten");

endmodule

FILE: dv/tb_scancode_set1_to_ascii.sv
`timescale 1ns / 100ps
// Self-checking testbench for the scan-code set 1 to ASCII decoder.
module tb_scancode_set1_to_ascii;

   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned RandomItems = 700;
   localparam int unsigned DrainCycles = 10;
   localparam int unsigned ReportLimit = 10;

   localparam logic [s1asc_pkg::ByteWidth-1:0] BreakBit = 8'h80;
   localparam logic [s1asc_pkg::ByteWidth-1:0] KeyEsc   = 8'h01;
   localparam logic [s1asc_pkg::ByteWidth-1:0] KeyOne   = 8'h02;
   localparam logic [s1asc_pkg::ByteWidth-1:0] KeyEqual = 8'h0D;
   localparam logic [s1asc_pkg::ByteWidth-1:0] KeyU     = 8'h16;
   localparam logic [s1asc_pkg::ByteWidth-1:0] KeyA     = 8'h1E;
   localparam logic [s1asc_pkg::ByteWidth-1:0] KeyL     = 8'h26;
   localparam logic [s1asc_pkg::ByteWidth-1:0] KeySpace = 8'h39;
   localparam logic [s1asc_pkg::ByteWidth-1:0] KeyNone  = 8'h00;
   localparam logic [s1asc_pkg::ByteWidth-1:0] KeyTop   = 8'h7F;

   // Decoder state mirror, character tables and queue of pending characters
   class char_scoreboard;
      bit prefix_seen;
      bit ctrl_down;
      bit shift_down;
      bit alt_down;
      bit caps_lock;
      logic [s1asc_pkg::CharWidth-1:0] expected_chars[$];
      int unsigned failures;

      logic [s1asc_pkg::CharWidth-1:0] plain_col [0:58] = '{
         7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
         7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
         7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
         7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00,
         7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
         7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
         7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
         7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00};

      logic [s1asc_pkg::CharWidth-1:0] shift_col [0:58] = '{
         7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
         7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
         7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
         7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00,
         7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
         7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
         7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
         7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00};

      function new();
         prefix_seen = 1'b0;
         ctrl_down   = 1'b0;
         shift_down  = 1'b0;
         alt_down    = 1'b0;
         caps_lock   = 1'b0;
         failures    = 0;
      endfunction

      // Digits and punctuation follow shift only
      function bit shift_only_key(logic [s1asc_pkg::ByteWidth-1:0] k);
         return k < 8'h0E || k == 8'h1A || k == 8'h1B || k == 8'h27 || k == 8'h28 ||
                k == 8'h29 || k == 8'h2B || k == 8'h33 || k == 8'h34 || k == 8'h35;
      endfunction

      // Apply one accepted byte; returns 1 when it emits or changes any state
      function bit note_scan_byte(logic [s1asc_pkg::ByteWidth-1:0] b);
         bit                              ext;
         bit                              upper;
         bit                              emitted;
         logic [4:0]                      state_before;
         logic [s1asc_pkg::CharWidth-1:0] made;
         logic [s1asc_pkg::CharWidth-1:0] ch;
         state_before = {prefix_seen, ctrl_down, shift_down, alt_down, caps_lock};
         emitted = 1'b0;
         ext = prefix_seen;
         prefix_seen = (b == s1asc_pkg::CodePrefix);
         if (b == s1asc_pkg::CodePrefix) begin
            // prefix only
         end else if (b[7]) begin
            // release: ctrl and alt clear with or without prefix, shift only without
            made = b[6:0];
            if (made == s1asc_pkg::CodeCtrl[6:0]) begin
               ctrl_down = 1'b0;
            end else if (made == s1asc_pkg::CodeAlt[6:0]) begin
               alt_down = 1'b0;
            end else if (!ext && (made == s1asc_pkg::CodeLShift[6:0] ||
                                  made == s1asc_pkg::CodeRShift[6:0])) begin
               shift_down = 1'b0;
            end
         end else if (ext ? (b == s1asc_pkg::CodeCtrl || b == s1asc_pkg::CodeAlt) :
                            (b != 0 && b < s1asc_pkg::KeyCount)) begin
            upper = (!ext && shift_only_key(b)) ? shift_down : (shift_down ^ caps_lock);
            ch = upper ? shift_col[int'(b)] : plain_col[int'(b)];
            if (ctrl_down && (ch == s1asc_pkg::CharLowL || ch == s1asc_pkg::CharLowU)) begin
               ch = ch - s1asc_pkg::CharLowA;
            end
            if (ch != 0) begin
               expected_chars.push_back(ch);
               emitted = 1'b1;
            end else if (b == s1asc_pkg::CodeCtrl) begin
               ctrl_down = 1'b1;
            end else if (b == s1asc_pkg::CodeAlt) begin
               alt_down = 1'b1;
            end else if (b == s1asc_pkg::CodeLShift || b == s1asc_pkg::CodeRShift) begin
               shift_down = 1'b1;
            end else if (b == s1asc_pkg::CodeCaps) begin
               caps_lock = ~caps_lock;
            end
         end
         return emitted ||
                state_before != {prefix_seen, ctrl_down, shift_down, alt_down, caps_lock};
      endfunction

      function void report(string what);
         failures++;
         if (failures <= ReportLimit) begin
            $display("[%0t] %s", $realtime, what);
         end
      endfunction

      // Compare one delivered character with the oldest pending one
      function void check_char(logic [s1asc_pkg::CharWidth-1:0] got);
         logic [s1asc_pkg::CharWidth-1:0] want;
         if (expected_chars.size() == 0) begin
            report($sformatf("unexpected character 0x%02h", got));
         end else begin
            want = expected_chars.pop_front();
            if (got !== want) begin
               report($sformatf("character mismatch: expected 0x%02h got 0x%02h", want, got));
            end
         end
      endfunction

      function int unsigned pending();
         return expected_chars.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [s1asc_pkg::ByteWidth-1:0] req_scan_byte;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [s1asc_pkg::CharWidth-1:0] rsp_ascii_char;

   char_scoreboard sb;
   int unsigned    send_idle_pct;
   int unsigned    recv_idle_pct;
   int unsigned    live_items;

   scancode_set1_to_ascii i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_scan_byte  (req_scan_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Random receiver stalls
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_char(rsp_ascii_char);
      end
   end

   // Watchdog
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   // One transaction on the request channel, with random idle before it
   task automatic send_byte(input logic [s1asc_pkg::ByteWidth-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_scan_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      void'(sb.note_scan_byte(b));
      live_items++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Typing key, with modifier keys steered away so modifiers only move in their own sequences
   function automatic logic [s1asc_pkg::ByteWidth-1:0] pick_key();
      int unsigned                     r;
      logic [s1asc_pkg::ByteWidth-1:0] k;
      r = $urandom_range(99);
      if (r < 4) begin
         k = KeyNone;
      end else if (r < 10) begin
         k = 8'($urandom_range(KeyTop, s1asc_pkg::KeyCount));
      end else begin
         k = 8'($urandom_range(s1asc_pkg::KeyCount - 1, 1));
         if (k == s1asc_pkg::CodeCtrl || k == s1asc_pkg::CodeAlt ||
             k == s1asc_pkg::CodeLShift || k == s1asc_pkg::CodeRShift ||
             k == s1asc_pkg::CodeCaps) begin
            k = KeyA;
         end
      end
      return k;
   endfunction

   task automatic type_keys(input int unsigned n, input bit ctrl_bias);
      logic [s1asc_pkg::ByteWidth-1:0] k;
      repeat (n) begin
         k = pick_key();
         if (ctrl_bias && $urandom_range(1)) begin
            k = $urandom_range(1) ? KeyL : KeyU;
         end
         send_byte(k);
         if ($urandom_range(1)) begin
            send_byte(k | BreakBit);
         end
      end
   endtask

   // Modifier held around a few keys, optionally with the extended prefix
   task automatic hold_modifier(input logic [s1asc_pkg::ByteWidth-1:0] mod,
                                input bit may_extend, input bit ctrl_bias);
      if (may_extend && $urandom_range(1)) begin
         send_byte(s1asc_pkg::CodePrefix);
      end
      send_byte(mod);
      type_keys($urandom_range(4, 1), ctrl_bias);
      if (may_extend && $urandom_range(1)) begin
         send_byte(s1asc_pkg::CodePrefix);
      end
      send_byte(mod | BreakBit);
   endtask

   task automatic play_sequence();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) begin
         type_keys($urandom_range(4, 1), 1'b0);
      end else if (r < 50) begin
         hold_modifier($urandom_range(1) ? s1asc_pkg::CodeLShift : s1asc_pkg::CodeRShift,
                       1'b0, 1'b0);
      end else if (r < 62) begin
         hold_modifier(s1asc_pkg::CodeCtrl, 1'b1, 1'b1);
      end else if (r < 70) begin
         send_byte(s1asc_pkg::CodeCaps);
         send_byte(s1asc_pkg::CodeCaps | BreakBit);
         type_keys($urandom_range(3, 1), 1'b0);
      end else if (r < 78) begin
         hold_modifier(s1asc_pkg::CodeAlt, 1'b1, 1'b0);
      end else if (r < 88) begin
         send_byte(s1asc_pkg::CodePrefix);
         send_byte(8'($urandom_range(255)));
      end else begin
         send_byte(8'($urandom_range(255)));
      end
   endtask

   // Directed opening: ignored codes, each modifier, caps, ctrl shortcut, prefix cases
   logic [s1asc_pkg::ByteWidth-1:0] opening [] = '{
      KeyNone, KeyTop, KeyTop | BreakBit, KeyEsc, s1asc_pkg::CodeCaps, KeyA, KeyOne,
      s1asc_pkg::CodeLShift, KeyA, KeyEqual, s1asc_pkg::CodeLShift | BreakBit,
      s1asc_pkg::CodeCaps, s1asc_pkg::CodeCtrl, KeyL, KeyU,
      s1asc_pkg::CodeCtrl | BreakBit, s1asc_pkg::CodePrefix, s1asc_pkg::CodePrefix,
      s1asc_pkg::CodeAlt, s1asc_pkg::CodePrefix, s1asc_pkg::CodeAlt | BreakBit,
      s1asc_pkg::CodePrefix, s1asc_pkg::CodeLShift | BreakBit, s1asc_pkg::CodePrefix,
      KeyA, s1asc_pkg::KeyCount, KeySpace};

   initial begin
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_scan_byte = '0;
      send_idle_pct = 24;
      recv_idle_pct = 69;
      live_items    = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening[i]) begin
         send_byte(opening[i]);
      end

      // Hold off the sender until everything has come out
      req_valid <= 1'b0;
      @(negedge clock);
      wait_drained();

      live_items = 0;
      while (live_items < RandomItems) begin
         if (live_items < RandomItems / 3) begin
            send_idle_pct = 24;
            recv_idle_pct = 69;
         end else if (live_items < 2 * RandomItems / 3) begin
            send_idle_pct = 69;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         play_sequence();
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d characters never delivered", sb.pending()));
      end
      if (sb.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
